// File: rtl/arpm_pkg.sv
// ---------------------------------------------------------------------------
// arpm_pkg: shared types and constants of the audio RMS and peak meter
// Widths, function codes, status codes and the queue entry format.
// ---------------------------------------------------------------------------
package arpm_pkg;

    // Longest chunk in samples; a sample that reaches it closes the chunk
    localparam int CHUNK_MAX = 256;

    localparam int SAMPLE_W = 16;
    localparam int FUNC_W   = 2;
    localparam int WORD_W   = 32;
    // Sample count per chunk, wide enough to hold CHUNK_MAX itself
    localparam int CNT_W    = $clog2(CHUNK_MAX + 1);
    // Square of a magnitude up to 32768 needs 31 bits
    localparam int SQ_W     = 2 * SAMPLE_W - 1;
    // Sum of up to CHUNK_MAX squares
    localparam int SUM_W    = SQ_W + $clog2(CHUNK_MAX);
    // Mean square fits the square width; radicand is padded to an even width
    localparam int RAD_W    = 2 * SAMPLE_W;
    localparam int ROOT_W   = SAMPLE_W;
    localparam int SREM_W   = ROOT_W + 2;
    localparam int STEP_W   = $clog2(SUM_W + 1);
    localparam int CNTR_W   = 32;
    localparam int STAT_W   = 2;
    localparam int THR_W    = 16;

    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);

    localparam int OUT_W      = 2 * SAMPLE_W + 2 * CNTR_W + STAT_W + 1;
    localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(4);

    // Function codes of an input item
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TIMEOUT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ERROR   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd3;

    // Status codes of a result
    localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NO_SIGNAL = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_ERROR     = 2'd2;

    // Register byte-address index of the threshold register
    localparam logic REG_THRESHOLD = 1'b0;

    // Classified item handed from the front to the back
    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [SAMPLE_W-1:0] mag;
        logic                close;
        logic [CNT_W-1:0]    count;
    } t_entry;

    // Push request from the front into the queue
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

endpackage

// File: rtl/arpm_front.sv
// ---------------------------------------------------------------------------
// arpm_front: input side of the meter
// Accepts stream items, takes the sample magnitude, tracks the chunk tally
// and marks the sample that closes a chunk.
// ---------------------------------------------------------------------------
module arpm_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_tvalid,
    output logic                         o_tready,
    input  logic [arpm_pkg::WORD_W-1:0]  i_tdata,
    input  logic [arpm_pkg::FUNC_W-1:0]  i_tuser,
    input  logic                         i_tlast,
    input  logic                         i_full,
    output arpm_pkg::t_push              o_push
);

    logic [arpm_pkg::CNT_W-1:0]    r_tally;
    logic [arpm_pkg::CNT_W-1:0]    n_tally;
    logic [arpm_pkg::SAMPLE_W-1:0] sample;
    logic [arpm_pkg::CNT_W-1:0]    count;
    logic                          accept;
    logic                          close;

    assign o_tready = !i_full;
    assign accept   = i_tvalid && !i_full;

    // Take the magnitude of the signed sample in the upper half of the word
    assign sample = i_tdata[arpm_pkg::WORD_W-1 -: arpm_pkg::SAMPLE_W];
    assign count  = r_tally + arpm_pkg::CNT_W'(1);
    assign close  = i_tlast || (count == arpm_pkg::CNT_W'(arpm_pkg::CHUNK_MAX));

    always_comb begin
        o_push.valid       = accept;
        o_push.entry.func  = i_tuser;
        o_push.entry.mag   = sample[arpm_pkg::SAMPLE_W-1] ? (arpm_pkg::SAMPLE_W'(0) - sample)
                                                          : sample;
        o_push.entry.close = close;
        o_push.entry.count = count;
    end

    // Advance the tally on samples, restart it on a close or any event
    always_comb begin
        n_tally = r_tally;
        if (accept) begin
            if (i_tuser == arpm_pkg::FUNC_SAMPLE && !close) begin
                n_tally = count;
            end else begin
                n_tally = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally <= '0;
        end else begin
            r_tally <= n_tally;
        end
    end

endmodule

// File: rtl/arpm_queue.sv
// ---------------------------------------------------------------------------
// arpm_queue: short FIFO between front and back
// Holds classified items so that either side can stall on its own.
// ---------------------------------------------------------------------------
module arpm_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  arpm_pkg::t_push   i_push,
    input  logic              i_pop,
    output arpm_pkg::t_entry  o_head,
    output logic              o_empty,
    output logic              o_full
);

    arpm_pkg::t_entry              r_mem [arpm_pkg::QDEPTH];
    logic [arpm_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [arpm_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [arpm_pkg::QPTR_W:0]     r_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (arpm_pkg::QPTR_W + 1)'(arpm_pkg::QDEPTH));
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store the entry at the write pointer
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

    // Move pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + arpm_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + arpm_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (arpm_pkg::QPTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (arpm_pkg::QPTR_W + 1)'(1);
            end
        end
    end

    ap_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> !o_full)
        else $error("queue push while full");

    ap_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue pop while empty");

    ap_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!do_push && !do_pop) |=> $stable(r_count))
        else $error("queue fill count moved without a transfer");

endmodule

// File: rtl/arpm_back.sv
// ---------------------------------------------------------------------------
// arpm_back: execution side of the meter
// Squares and accumulates samples, divides the sum by the count and takes
// the square root bit by bit at chunk close, applies events and holds the
// result in an output register.
// ---------------------------------------------------------------------------
module arpm_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  arpm_pkg::t_entry                 i_head,
    input  logic                             i_empty,
    output logic                             o_pop,
    input  logic [arpm_pkg::THR_W-1:0]       i_threshold,
    output logic                             o_tvalid,
    input  logic                             i_tready,
    output logic [arpm_pkg::OUT_DATA_W-1:0]  o_tdata
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_SQRT = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]                      r_state;
    logic [2:0]                      n_state;

    // Current item
    logic [arpm_pkg::FUNC_W-1:0]     r_func;
    logic [arpm_pkg::SAMPLE_W-1:0]   r_mag;
    logic                            r_close;
    logic [arpm_pkg::CNT_W-1:0]      r_cnt;
    logic [arpm_pkg::SQ_W-1:0]       r_sq;

    // Accumulators
    logic [arpm_pkg::SUM_W-1:0]      r_sum;
    logic [arpm_pkg::SAMPLE_W-1:0]   r_peak;

    // Divider and square root
    logic [arpm_pkg::STEP_W-1:0]     r_step;
    logic [arpm_pkg::SUM_W-1:0]      r_dvd;
    logic [arpm_pkg::CNT_W-1:0]      r_rem;
    logic [arpm_pkg::RAD_W-1:0]      r_rad;
    logic [arpm_pkg::SREM_W-1:0]     r_srem;
    logic [arpm_pkg::ROOT_W-1:0]     r_root;

    // Held values
    logic [arpm_pkg::SAMPLE_W-1:0]   r_held_rms;
    logic [arpm_pkg::SAMPLE_W-1:0]   r_held_peak;
    logic [arpm_pkg::CNTR_W-1:0]     r_chunks;
    logic [arpm_pkg::CNTR_W-1:0]     r_errors;
    logic [arpm_pkg::STAT_W-1:0]     r_status;
    logic                            r_ready;
    logic [arpm_pkg::SAMPLE_W-1:0]   n_held_rms;
    logic [arpm_pkg::SAMPLE_W-1:0]   n_held_peak;
    logic [arpm_pkg::CNTR_W-1:0]     n_chunks;
    logic [arpm_pkg::CNTR_W-1:0]     n_errors;
    logic [arpm_pkg::STAT_W-1:0]     n_status;
    logic                            n_ready;

    // Output register
    logic                            r_out_valid;
    logic [arpm_pkg::OUT_DATA_W-1:0] r_out_data;

    logic                            out_free;
    logic                            emit;
    logic [arpm_pkg::SUM_W-1:0]      sum_total;
    logic [arpm_pkg::CNT_W:0]        rem_sh;
    logic                            div_ge;
    logic [arpm_pkg::CNT_W:0]        rem_sub;
    logic [arpm_pkg::SREM_W+1:0]     srem_sh;
    logic [arpm_pkg::SREM_W+1:0]     trial;
    logic                            sq_ge;
    logic [arpm_pkg::SREM_W+1:0]     srem_sub;

    assign out_free  = !r_out_valid || i_tready;
    assign emit      = (r_state == ST_EMIT) && out_free;
    assign o_pop     = (r_state == ST_IDLE) && !i_empty;
    assign o_tvalid  = r_out_valid;
    assign o_tdata   = r_out_data;
    assign sum_total = r_sum + arpm_pkg::SUM_W'(r_sq);

    // One restoring division step: bring down one dividend bit
    assign rem_sh  = {r_rem, r_dvd[arpm_pkg::SUM_W-1]};
    assign div_ge  = (rem_sh >= {1'b0, r_cnt});
    assign rem_sub = rem_sh - {1'b0, r_cnt};

    // One square root step: bring down two radicand bits
    assign srem_sh  = {r_srem, r_rad[arpm_pkg::RAD_W-1 -: 2]};
    assign trial    = (arpm_pkg::SREM_W + 2)'({r_root, 2'b01});
    assign sq_ge    = (srem_sh >= trial);
    assign srem_sub = srem_sh - trial;

    // Sequence one item
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_func != arpm_pkg::FUNC_SAMPLE) begin
                    n_state = ST_EMIT;
                end else if (r_close) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (r_step == arpm_pkg::STEP_W'(1)) begin
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (r_step == arpm_pkg::STEP_W'(1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Work out the held values that the current item leaves
    always_comb begin
        n_held_rms  = r_held_rms;
        n_held_peak = r_held_peak;
        n_chunks    = r_chunks;
        n_errors    = r_errors;
        n_status    = r_status;
        n_ready     = r_ready;
        unique case (r_func)
            arpm_pkg::FUNC_SAMPLE: begin
                n_held_rms  = r_root;
                n_held_peak = r_peak;
                n_chunks    = r_chunks + arpm_pkg::CNTR_W'(1);
                n_status    = (r_root > i_threshold) ? arpm_pkg::STATUS_OK
                                                     : arpm_pkg::STATUS_NO_SIGNAL;
            end
            arpm_pkg::FUNC_TIMEOUT: begin
                n_held_rms  = '0;
                n_held_peak = '0;
                n_status    = arpm_pkg::STATUS_NO_SIGNAL;
            end
            arpm_pkg::FUNC_ERROR: begin
                n_errors    = r_errors + arpm_pkg::CNTR_W'(1);
                n_ready     = 1'b0;
                n_status    = arpm_pkg::STATUS_ERROR;
            end
            arpm_pkg::FUNC_CLEAR: begin
                n_held_rms  = '0;
                n_held_peak = '0;
                n_chunks    = '0;
                n_errors    = '0;
                if (r_ready) begin
                    n_status = arpm_pkg::STATUS_OK;
                end
            end
            default: begin
                n_status = r_status;
            end
        endcase
    end

    // Control state, accumulators and held values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_peak      <= '0;
            r_held_rms  <= '0;
            r_held_peak <= '0;
            r_chunks    <= '0;
            r_errors    <= '0;
            r_status    <= arpm_pkg::STATUS_OK;
            r_ready     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // Accumulate a sample
            if (r_state == ST_EXEC && r_func == arpm_pkg::FUNC_SAMPLE) begin
                r_sum <= sum_total;
                if (r_mag > r_peak) begin
                    r_peak <= r_mag;
                end
            end
            // Commit a result and drop the partial chunk
            if (emit) begin
                r_sum       <= '0;
                r_peak      <= '0;
                r_held_rms  <= n_held_rms;
                r_held_peak <= n_held_peak;
                r_chunks    <= n_chunks;
                r_errors    <= n_errors;
                r_status    <= n_status;
                r_ready     <= n_ready;
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_func  <= i_head.func;
            r_mag   <= i_head.mag;
            r_close <= i_head.close;
            r_cnt   <= i_head.count;
            r_sq    <= arpm_pkg::SQ_W'({arpm_pkg::SAMPLE_W'(0), i_head.mag}
                                       * {arpm_pkg::SAMPLE_W'(0), i_head.mag});
        end
        unique case (r_state)
            ST_EXEC: begin
                r_dvd  <= sum_total;
                r_rem  <= '0;
                r_step <= arpm_pkg::STEP_W'(arpm_pkg::SUM_W);
            end
            ST_DIV: begin
                r_dvd  <= {r_dvd[arpm_pkg::SUM_W-2:0], div_ge};
                r_rem  <= div_ge ? rem_sub[arpm_pkg::CNT_W-1:0] : rem_sh[arpm_pkg::CNT_W-1:0];
                if (r_step == arpm_pkg::STEP_W'(1)) begin
                    r_rad  <= {1'b0, r_dvd[arpm_pkg::SQ_W-2:0], div_ge};
                    r_srem <= '0;
                    r_root <= '0;
                    r_step <= arpm_pkg::STEP_W'(arpm_pkg::ROOT_W);
                end else begin
                    r_step <= r_step - arpm_pkg::STEP_W'(1);
                end
            end
            ST_SQRT: begin
                r_rad  <= {r_rad[arpm_pkg::RAD_W-3:0], 2'b00};
                r_srem <= sq_ge ? srem_sub[arpm_pkg::SREM_W-1:0]
                                : srem_sh[arpm_pkg::SREM_W-1:0];
                r_root <= {r_root[arpm_pkg::ROOT_W-2:0], sq_ge};
                r_step <= r_step - arpm_pkg::STEP_W'(1);
            end
            default: begin
                r_step <= r_step;
            end
        endcase
        // Load the output register
        if (emit) begin
            r_out_data <= arpm_pkg::OUT_DATA_W'({n_ready, n_status, n_errors, n_chunks,
                                                 n_held_peak, n_held_rms});
        end
    end

    ap_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> ({1'b0, r_rem} < {1'b0, r_cnt}))
        else $error("division remainder reached the divisor");

    ap_square_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |-> (r_sq <= (arpm_pkg::SQ_W'(1) << (arpm_pkg::SQ_W - 1))))
        else $error("sample square out of range");

    ap_emit_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_state == ST_IDLE) && r_out_valid && (r_sum == '0))
        else $error("result commit did not finish the item");

    ap_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == ST_EXEC))
        else $error("queue entry taken outside idle");

endmodule

// File: rtl/audio_rms_peak_meter_core.sv
// Flow: an input item is queued, then fetched by the back end when idle.
// Each sample is fetched and accumulated; an event goes on to the output
// register, and a chunk close first runs the one-bit-a-cycle divider and
// the square root. The queue takes new items while the back end works.
// Reset: synchronous, active low; clears control state, counters and held
// levels, sets ready, threshold to 4.
// ---------------------------------------------------------------------------
// audio_rms_peak_meter_core: RMS and peak level meter for microphone words
// Front end classifies stream items into a short queue; the back end
// accumulates, divides, takes the root and presents held levels.
// ---------------------------------------------------------------------------
module audio_rms_peak_meter_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [arpm_pkg::WORD_W-1:0]      s_axis_tdata,   // [31:0] raw_word
    input  logic [arpm_pkg::FUNC_W-1:0]      s_axis_tuser,   // [1:0] func
    input  logic                             s_axis_tlast,   // last_sample
    // Result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [15:0] rms_level, [31:16] peak_level, [63:32] chunk_total,
    // [95:64] error_total, [97:96] status_code, [98] mic_ready, rest zero
    output logic [arpm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // Register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    logic [arpm_pkg::THR_W-1:0] r_threshold;
    arpm_pkg::t_push            push;
    arpm_pkg::t_entry           head;
    logic                       q_empty;
    logic                       q_full;
    logic                       pop;

    // Register write and read
    assign pready = 1'b1;
    assign prdata = (paddr[2] == arpm_pkg::REG_THRESHOLD) ? 32'(r_threshold) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= arpm_pkg::THRESHOLD_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == arpm_pkg::REG_THRESHOLD) begin
            r_threshold <= pwdata[arpm_pkg::THR_W-1:0];
        end
    end

    arpm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_tlast  (s_axis_tlast),
        .i_full   (q_full),
        .o_push   (push)
    );

    arpm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    arpm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .i_threshold (r_threshold),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata)
    );

endmodule

// File: sim/arpm_level_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// arpm_level_checker: result checker for the audio RMS and peak meter
// Watches the input, result and register channels, keeps its own copy of
// the meter state, predicts each report and compares it field by field.
// ---------------------------------------------------------------------------
module arpm_level_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input channel
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [arpm_pkg::WORD_W-1:0]      i_in_word,    // [31:0] raw_word
    input  logic [arpm_pkg::FUNC_W-1:0]      i_in_func,    // [1:0] func
    input  logic                             i_in_last,
    // Result channel
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    // [15:0] rms_level, [31:16] peak_level, [63:32] chunk_total,
    // [95:64] error_total, [97:96] status_code, [98] mic_ready, rest zero
    input  logic [arpm_pkg::OUT_DATA_W-1:0]  i_out_data,
    // Register port
    input  logic                             i_psel,
    input  logic                             i_penable,
    input  logic                             i_pwrite,
    input  logic [2:0]                       i_paddr,
    input  logic [31:0]                      i_pwdata,
    input  logic [31:0]                      i_prdata,
    input  logic                             i_pready,
    // Verdict
    output int                               o_pending,
    output int                               o_fail_count
);
    import arpm_pkg::*;

    typedef struct packed {
        logic [SAMPLE_W-1:0] rms;
        logic [SAMPLE_W-1:0] peak;
        logic [CNTR_W-1:0]   chunks;
        logic [CNTR_W-1:0]   errors;
        logic [STAT_W-1:0]   status;
        logic                ready;
    } meter_report_t;

    meter_report_t       expected_reports[$];

    // Meter state mirrored from the block
    logic [SUM_W-1:0]    square_acc;
    int unsigned         samples_in_chunk;
    logic [SAMPLE_W-1:0] chunk_peak;
    logic [SAMPLE_W-1:0] rms_hold;
    logic [SAMPLE_W-1:0] peak_hold;
    logic [CNTR_W-1:0]   chunk_cnt;
    logic [CNTR_W-1:0]   error_cnt;
    logic [STAT_W-1:0]   status_hold;
    logic                mic_ok;
    logic [THR_W-1:0]    threshold;

    // Integer square root, rounded down
    function automatic logic [SAMPLE_W-1:0] floor_root(input longint unsigned value);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = SAMPLE_W; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= value) root = trial;
        end
        return root[SAMPLE_W-1:0];
    endfunction

    task automatic clear_chunk();
        square_acc       = '0;
        samples_in_chunk = 0;
        chunk_peak       = '0;
    endtask

    task automatic reset_meter();
        clear_chunk();
        rms_hold    = '0;
        peak_hold   = '0;
        chunk_cnt   = '0;
        error_cnt   = '0;
        status_hold = STATUS_OK;
        mic_ok      = 1'b1;
        threshold   = THRESHOLD_RESET;
        expected_reports.delete();
    endtask

    // Advance the meter by one input transfer and queue the report it causes
    task automatic predict_report(input logic [FUNC_W-1:0] func,
                                  input logic [WORD_W-1:0] word,
                                  input logic last);
        logic [SAMPLE_W-1:0] pcm;
        logic [SAMPLE_W:0]   mag;
        longint unsigned     mean_square;
        pcm = word[WORD_W-1 -: SAMPLE_W];
        mag = pcm[SAMPLE_W-1] ? ((SAMPLE_W+1)'(1) << SAMPLE_W) - {1'b0, pcm} : {1'b0, pcm};
        case (func)
            FUNC_SAMPLE: begin
                square_acc = square_acc + mag * mag;
                if (mag > chunk_peak) chunk_peak = mag[SAMPLE_W-1:0];
                samples_in_chunk++;
                // hold the chunk open until last or the length limit
                if (!last && samples_in_chunk < CHUNK_MAX) return;
                mean_square = 64'(square_acc) / 64'(samples_in_chunk);
                rms_hold    = floor_root(mean_square);
                peak_hold   = chunk_peak;
                chunk_cnt   = chunk_cnt + 1;
                status_hold = (rms_hold > threshold) ? STATUS_OK : STATUS_NO_SIGNAL;
                clear_chunk();
            end
            FUNC_TIMEOUT: begin
                clear_chunk();
                rms_hold    = '0;
                peak_hold   = '0;
                status_hold = STATUS_NO_SIGNAL;
            end
            FUNC_ERROR: begin
                clear_chunk();
                error_cnt   = error_cnt + 1;
                mic_ok      = 1'b0;
                status_hold = STATUS_ERROR;
            end
            default: begin
                clear_chunk();
                rms_hold  = '0;
                peak_hold = '0;
                chunk_cnt = '0;
                error_cnt = '0;
                // an error status survives a clear once the mic has failed
                if (mic_ok) status_hold = STATUS_OK;
            end
        endcase
        expected_reports.push_back('{rms_hold, peak_hold, chunk_cnt, error_cnt,
                                     status_hold, mic_ok});
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    // Compare a result transfer against the oldest queued report
    task automatic compare_report(input logic [OUT_DATA_W-1:0] data);
        meter_report_t want;
        if (expected_reports.size() == 0) begin
            $error("result transfer with no report pending: %h", data);
            o_fail_count++;
            return;
        end
        want = expected_reports.pop_front();
        check_field("rms_level",   want.rms,    data[15:0]);
        check_field("peak_level",  want.peak,   data[31:16]);
        check_field("chunk_total", want.chunks, data[63:32]);
        check_field("error_total", want.errors, data[95:64]);
        check_field("status_code", want.status, data[97:96]);
        check_field("mic_ready",   want.ready,  data[98]);
        check_field("padding",     0,           data[OUT_DATA_W-1:OUT_W]);
    endtask

    // Sample every channel at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_meter();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr[2] == REG_THRESHOLD) threshold = i_pwdata[THR_W-1:0];
                end else if (i_paddr[2] == REG_THRESHOLD) begin
                    check_field("threshold readback", threshold, i_prdata);
                end
            end
            if (i_out_valid && i_out_ready) compare_report(i_out_data);
            if (i_in_valid && i_in_ready) predict_report(i_in_func, i_in_word, i_in_last);
        end
        o_pending = expected_reports.size();
    end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: testbench for the audio RMS and peak meter core
// Drives directed and random sample chunks and events with random idle gaps
// and back-pressure, rewrites the threshold between phases and reports the
// verdict from the checker's failure count.
// ---------------------------------------------------------------------------
module tb_top;
    import arpm_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int FULL_SCALE     = 32768;

    localparam logic [2:0] THRESHOLD_ADDR = 3'd0;
    localparam logic [2:0] SPARE_ADDR     = 3'd4;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [WORD_W-1:0]     s_axis_tdata = '0;     // [31:0] raw_word
    logic [FUNC_W-1:0]     s_axis_tuser = FUNC_SAMPLE;  // [1:0] func
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [15:0] rms_level, [31:16] peak_level, [63:32] chunk_total,
    // [95:64] error_total, [97:96] status_code, [98] mic_ready, rest zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [2:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    int                    pending_reports;
    int                    fail_count;
    int                    items_sent = 0;
    int                    cur_threshold = THRESHOLD_RESET;
    int                    idle_cycles = 0;
    int                    rx_stall_left = 0;
    bit                    sender_calm = 1'b0;
    bit                    rx_calm = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    audio_rms_peak_meter_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    arpm_level_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_word    (s_axis_tdata),
        .i_in_func    (s_axis_tuser),
        .i_in_last    (s_axis_tlast),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_pending    (pending_reports),
        .o_fail_count (fail_count)
    );

    // Result back-pressure: mostly short stalls, a few long ones
    always @(negedge i_clk) begin
        if (rx_stall_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall_left = rx_stall_left - 1;
        end else if (!rx_calm && $urandom_range(0, 99) < 25) begin
            m_axis_tready <= 1'b0;
            rx_stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                        : $urandom_range(0, 2);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (sender_calm || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one item and hold it until the transfer
    task automatic send_item(input logic [FUNC_W-1:0] func, input logic [WORD_W-1:0] word,
                             input logic last);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= word;
        s_axis_tuser  <= func;
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Put the PCM value in the upper half; the lower half is random filler
    task automatic send_sample(input int pcm, input logic last);
        logic [31:0] filler;
        logic [15:0] pcm_bits;
        filler   = $urandom();
        pcm_bits = 16'(pcm);
        send_item(FUNC_SAMPLE, {pcm_bits, filler[15:0]}, last);
    endtask

    // One chunk at a level picked to land below, near or above the threshold
    task automatic send_chunk(input int len, input bit with_last);
        int mode;
        int amp;
        int pcm;
        bit steady;
        mode = $urandom_range(0, 9);
        if (mode < 3) amp = $urandom_range(0, 2 * cur_threshold + 2);
        else if (mode < 5) amp = cur_threshold + $urandom_range(0, 1);
        else if (mode < 8) amp = $urandom_range(0, FULL_SCALE);
        else amp = FULL_SCALE;
        if (amp > FULL_SCALE) amp = FULL_SCALE;
        steady = (mode == 3) || (mode == 4) || ($urandom_range(0, 19) == 0);
        for (int k = 0; k < len; k++) begin
            if (steady) pcm = $urandom_range(0, 1) ? amp : -amp;
            else pcm = int'($urandom_range(0, 2 * amp)) - amp;
            if (pcm > FULL_SCALE - 1) pcm = FULL_SCALE - 1;
            send_sample(pcm, with_last && (k == len - 1));
        end
    endtask

    // Mostly well-formed chunks, some events, broken chunks and stray words
    task automatic run_random(input int count);
        int stop_at;
        int roll;
        int len;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 29) == 0) sender_calm = !sender_calm;
            if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
                if ($urandom_range(0, 9) == 0) begin
                    send_chunk(len, 1'b0);
                    send_item(FUNC_W'($urandom_range(FUNC_TIMEOUT, FUNC_CLEAR)),
                              $urandom(), 1'($urandom()));
                end else begin
                    send_chunk(len, 1'b1);
                end
            end else if (roll < 85) begin
                send_item(FUNC_TIMEOUT, $urandom(), 1'($urandom()));
            end else if (roll < 91) begin
                send_item(FUNC_CLEAR, $urandom(), 1'($urandom()));
            end else if (roll < 94) begin
                send_item(FUNC_ERROR, $urandom(), 1'($urandom()));
            end else begin
                send_item(FUNC_SAMPLE, $urandom(), 1'($urandom()));
            end
        end
        sender_calm = 1'b0;
        rx_calm     = 1'b0;
    endtask

    // Stop sending, wait for every report, then let a chunk close finish
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (pending_reports == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Setup cycle, access cycle, then release the bus
    task automatic reg_access(input logic write, input logic [2:0] addr,
                              input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_threshold(input logic [2:0] addr, input logic [31:0] data);
        reg_access(1'b1, addr, data);
        if (addr[2] == REG_THRESHOLD) cur_threshold = data[THR_W-1:0];
        reg_access(1'b0, THRESHOLD_ADDR, '0);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset value of the threshold
        reg_access(1'b0, THRESHOLD_ADDR, '0);

        // Directed: extremes, threshold edge, events inside chunks
        send_sample(FULL_SCALE - 1, 1'b1);
        send_sample(-FULL_SCALE, 1'b1);
        send_sample(0, 1'b1);
        send_sample(5, 1'b0);
        send_sample(-5, 1'b1);
        send_sample(4, 1'b1);
        send_sample(3, 1'b0);
        send_sample(-4, 1'b0);
        send_item(FUNC_TIMEOUT, 32'hFFFF_FFFF, 1'b1);
        send_sample(1, 1'b0);
        send_item(FUNC_CLEAR, '0, 1'b0);
        send_sample(2, 1'b1);
        send_sample(-FULL_SCALE, 1'b0);
        send_sample(FULL_SCALE - 1, 1'b0);
        send_sample(1, 1'b1);
        send_item(FUNC_TIMEOUT, '0, 1'b0);
        send_item(FUNC_CLEAR, 32'hFFFF_FFFF, 1'b1);
        send_sample(-3, 1'b0);
        send_item(FUNC_ERROR, 32'h8000_0000, 1'b1);
        send_sample(100, 1'b1);
        send_item(FUNC_ERROR, '0, 1'b0);
        send_item(FUNC_CLEAR, '0, 1'b0);
        send_sample(0, 1'b1);
        drain();

        // Lowest threshold
        set_threshold(THRESHOLD_ADDR, 32'd0);
        run_random(200);
        drain();

        // Threshold at full scale
        set_threshold(THRESHOLD_ADDR, 32'd32768);
        run_random(60);
        drain();

        // Upper value bits and the unused register are ignored
        set_threshold(THRESHOLD_ADDR, 32'hFFFF_0010);
        set_threshold(SPARE_ADDR, $urandom());
        // Chunk length limit without last, then with last on the limit
        send_chunk(CHUNK_MAX + 4, 1'b1);
        send_chunk(CHUNK_MAX, 1'b1);
        run_random(120);
        drain();

        set_threshold(THRESHOLD_ADDR, $urandom_range(0, FULL_SCALE));
        run_random(80);
        drain();

        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/arpm_pkg.sv
rtl/arpm_front.sv
rtl/arpm_queue.sv
rtl/arpm_back.sv
rtl/audio_rms_peak_meter_core.sv
sim/arpm_level_checker.sv
sim/tb_top.sv
